// File: hw/rtl/fbf_pkg.sv
// Package for the ARGB32 fill engine: store geometry, command codes,
// queue entry and register types. No dependencies.

package fbf_pkg;

  localparam int STORE_WORDS = 4096;              // power of two, address wraps
  localparam int AW          = $clog2(STORE_WORDS);
  localparam int PIXW        = 32;
  localparam int CW          = 12;                // signed coordinate width
  localparam int UW          = 11;                // in-range coordinate width
  localparam int PITCHW      = 12;
  localparam int BASEW       = 12;
  localparam int MULW        = UW + PITCHW;
  localparam int SUMW        = MULW + 1;
  localparam int QDEPTH      = 2;
  localparam int QAW         = $clog2(QDEPTH);
  localparam int PAW         = 4;

  typedef enum logic [2:0] {
    FN_SET   = 3'd0,
    FN_GET   = 3'd1,
    FN_HLINE = 3'd2,
    FN_VLINE = 3'd3,
    FN_RECT  = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_PITCH  = 2'd2,
    REG_BASE   = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    K_DRAW,
    K_READ,
    K_REJECT,
    K_NOP
  } kind_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_ROW,
    B_PIX,
    B_RDWAIT
  } bstate_e;

  typedef struct packed {
    logic [UW-1:0]     fb_width;
    logic [UW-1:0]     fb_height;
    logic [PITCHW-1:0] row_pitch;
    logic [BASEW-1:0]  base_word;
  } cfg_t;

  typedef struct packed {
    kind_e           kind;
    logic [UW-1:0]   x_lo;
    logic [UW-1:0]   x_hi;
    logic [UW-1:0]   y_lo;
    logic [UW-1:0]   y_hi;
    logic [PIXW-1:0] color;
  } cmd_t;

  function automatic logic in_range(logic [CW-1:0] v, logic [UW-1:0] lim);
    return !v[CW-1] && (v[UW-1:0] < lim);
  endfunction

endpackage

// File: hw/rtl/argb32_framebuffer_fill_engine_core.sv
// Top level of the ARGB32 fill engine: register port, front end, command
// queue and back end. Depends on fbf_pkg, fbf_front, fbf_queue, fbf_back.
//
//   channel   | handshake                         | payload
//   ----------+-----------------------------------+----------------------------------
//   command   | start_i, busy_o (taken if !busy)  | func_i, x_a_i, y_a_i, x_b_i,
//             |                                   | y_b_i, color_i
//   result    | done_o (one-cycle strobe)         | read_color_o, status_o
//   registers | psel, penable, pwrite, pready     | paddr, pwdata, prdata
//
// A command is checked and queued in the cycle it is taken; busy_o rises only
// when the two-entry queue is full. The back end pulls one command at a time:
// rejected or empty commands answer in the cycle after leaving the queue, get
// pixel passes B_ROW, B_PIX and B_RDWAIT, drawing B_ROW and then B_PIX, one
// store write per cycle. Reset loads the register defaults and empties the
// queue; the store is not cleared. Results cannot be held off by the receiver.

module argb32_framebuffer_fill_engine_core import fbf_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  logic [2:0]      func_i,
  input  logic [CW-1:0]   x_a_i,
  input  logic [CW-1:0]   y_a_i,
  input  logic [CW-1:0]   x_b_i,
  input  logic [CW-1:0]   y_b_i,
  input  logic [PIXW-1:0] color_i,
  output logic            done_o,
  output logic [PIXW-1:0] read_color_o,
  output logic            status_o,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [PAW-1:0]  paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  cfg_t cfg_q;
  cmd_t front_cmd, head;
  logic push, pop, q_full, q_empty;
  logic cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fb_width  <= UW'(64);
      cfg_q.fb_height <= UW'(64);
      cfg_q.row_pitch <= PITCHW'(64);
      cfg_q.base_word <= '0;
    end else if (cfg_we) begin
      unique case (reg_e'(paddr[3:2]))
        REG_WIDTH:  cfg_q.fb_width  <= pwdata[UW-1:0];
        REG_HEIGHT: cfg_q.fb_height <= pwdata[UW-1:0];
        REG_PITCH:  cfg_q.row_pitch <= pwdata[PITCHW-1:0];
        REG_BASE:   cfg_q.base_word <= pwdata[BASEW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_e'(paddr[3:2]))
      REG_WIDTH:  prdata = 32'(cfg_q.fb_width);
      REG_HEIGHT: prdata = 32'(cfg_q.fb_height);
      REG_PITCH:  prdata = 32'(cfg_q.row_pitch);
      REG_BASE:   prdata = 32'(cfg_q.base_word);
      default:    prdata = '0;
    endcase
  end

  fbf_front u_front (
    .func_i  (func_i),
    .x_a_i   (x_a_i),
    .y_a_i   (y_a_i),
    .x_b_i   (x_b_i),
    .y_b_i   (y_b_i),
    .color_i (color_i),
    .cfg_i   (cfg_q),
    .cmd_o   (front_cmd)
  );

  assign busy_o = q_full;
  assign push   = start_i && !q_full;

  fbf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .pop_i   (pop),
    .head_o  (head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  fbf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_i       (head),
    .empty_i      (q_empty),
    .pop_o        (pop),
    .done_o       (done_o),
    .read_color_o (read_color_o),
    .status_o     (status_o)
  );

endmodule

// File: hw/rtl/fbf_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.

module fbf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/fbf_front.sv
// Front end: checks coordinates against the visible area and puts the
// line ends and the rect x ends in order. Depends on fbf_pkg.

module fbf_front import fbf_pkg::*; (
  input  logic [2:0]      func_i,
  input  logic [CW-1:0]   x_a_i,
  input  logic [CW-1:0]   y_a_i,
  input  logic [CW-1:0]   x_b_i,
  input  logic [CW-1:0]   y_b_i,
  input  logic [PIXW-1:0] color_i,
  input  cfg_t            cfg_i,
  output cmd_t            cmd_o
);

  logic          xa_ok, xb_ok, ya_ok, yb_ok;
  logic [UW-1:0] xa, xb, ya, yb;
  logic          x_swap, y_swap;

  always_comb begin
    xa_ok  = in_range(x_a_i, cfg_i.fb_width);
    xb_ok  = in_range(x_b_i, cfg_i.fb_width);
    ya_ok  = in_range(y_a_i, cfg_i.fb_height);
    yb_ok  = in_range(y_b_i, cfg_i.fb_height);
    xa     = x_a_i[UW-1:0];
    xb     = x_b_i[UW-1:0];
    ya     = y_a_i[UW-1:0];
    yb     = y_b_i[UW-1:0];
    // only meaningful when both ends are in range (both non-negative)
    x_swap = xb < xa;
    y_swap = yb < ya;

    cmd_o.kind  = K_REJECT;
    cmd_o.x_lo  = xa;
    cmd_o.x_hi  = xa;
    cmd_o.y_lo  = ya;
    cmd_o.y_hi  = ya;
    cmd_o.color = color_i;

    unique case (func_e'(func_i))
      FN_SET: begin
        if (xa_ok && ya_ok) cmd_o.kind = K_DRAW;
      end
      FN_GET: begin
        if (xa_ok && ya_ok) cmd_o.kind = K_READ;
      end
      FN_HLINE: begin
        if (ya_ok && xa_ok && xb_ok) cmd_o.kind = K_DRAW;
        cmd_o.x_lo = x_swap ? xb : xa;
        cmd_o.x_hi = x_swap ? xa : xb;
      end
      FN_VLINE: begin
        if (xa_ok && ya_ok && yb_ok) cmd_o.kind = K_DRAW;
        cmd_o.y_lo = y_swap ? yb : ya;
        cmd_o.y_hi = y_swap ? ya : yb;
      end
      FN_RECT: begin
        if (xa_ok && xb_ok && ya_ok && yb_ok) begin
          cmd_o.kind = y_swap ? K_NOP : K_DRAW;
        end
        cmd_o.x_lo = x_swap ? xb : xa;
        cmd_o.x_hi = x_swap ? xa : xb;
        cmd_o.y_lo = ya;
        cmd_o.y_hi = yb;
      end
      default: cmd_o.kind = K_REJECT;
    endcase
  end

endmodule

// File: hw/rtl/fbf_queue.sv
// Short command queue between front and back end.
// Depends on fbf_pkg.

module fbf_queue import fbf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output cmd_t head_o,
  output logic full_o,
  output logic empty_o
);

  cmd_t           mem_q [QDEPTH];
  logic [QAW-1:0] wr_q, rd_q;
  logic [QAW:0]   cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= cmd_i;
  end

  assign head_o  = mem_q[rd_q];
  assign full_o  = cnt_q == (QAW+1)'(QDEPTH);
  assign empty_o = cnt_q == '0;

endmodule

// File: hw/rtl/fbf_back.sv
// Back end: walks the pixels of each queued draw or read command over the
// store and produces the one-cycle result. Depends on fbf_pkg and fbf_ram.

module fbf_back import fbf_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cfg_t            cfg_i,
  input  cmd_t            head_i,
  input  logic            empty_i,
  output logic            pop_o,
  output logic            done_o,
  output logic [PIXW-1:0] read_color_o,
  output logic            status_o
);

  bstate_e         state_q, state_d;
  cmd_t            cur_q, cur_d;
  logic [UW-1:0]   x_q, x_d, y_q, y_d;
  logic [AW-1:0]   row_q, row_d;
  logic            res_valid_q, res_valid_d;
  logic [PIXW-1:0] res_color_q, res_color_d;
  logic            res_status_q, res_status_d;

  logic            ram_we;
  logic [AW-1:0]   ram_addr;
  logic [PIXW-1:0] ram_rdata;
  logic [MULW-1:0] prod;
  logic [SUMW-1:0] row_sum;

  fbf_ram #(
    .WIDTH (PIXW),
    .DEPTH (STORE_WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (cur_q.color),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q        <= cur_d;
    x_q          <= x_d;
    y_q          <= y_d;
    row_q        <= row_d;
    res_color_q  <= res_color_d;
    res_status_q <= res_status_d;
  end

  always_comb begin
    state_d      = state_q;
    cur_d        = cur_q;
    x_d          = x_q;
    y_d          = y_q;
    row_d        = row_q;
    res_valid_d  = 1'b0;
    res_color_d  = '0;
    res_status_d = 1'b0;
    pop_o        = 1'b0;
    ram_we       = 1'b0;
    ram_addr     = row_q + AW'(x_q);
    prod         = cur_q.y_lo * cfg_i.row_pitch;
    row_sum      = SUMW'(prod) + SUMW'(cfg_i.base_word);

    unique case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          cur_d = head_i;
          unique case (head_i.kind)
            K_REJECT: begin
              res_valid_d  = 1'b1;
              res_status_d = 1'b1;
            end
            K_NOP: begin
              res_valid_d = 1'b1;
            end
            default: state_d = B_ROW;
          endcase
        end
      end
      B_ROW: begin
        // address of the first row, later rows step by the pitch
        row_d   = row_sum[AW-1:0];
        x_d     = cur_q.x_lo;
        y_d     = cur_q.y_lo;
        state_d = B_PIX;
      end
      B_PIX: begin
        if (cur_q.kind == K_READ) begin
          state_d = B_RDWAIT;
        end else begin
          ram_we = 1'b1;
          if (x_q == cur_q.x_hi) begin
            if (y_q == cur_q.y_hi) begin
              res_valid_d = 1'b1;
              state_d     = B_IDLE;
            end else begin
              y_d   = y_q + 1'b1;
              x_d   = cur_q.x_lo;
              row_d = row_q + AW'(cfg_i.row_pitch);
            end
          end else begin
            x_d = x_q + 1'b1;
          end
        end
      end
      B_RDWAIT: begin
        res_valid_d = 1'b1;
        res_color_d = ram_rdata;
        state_d     = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  assign done_o       = res_valid_q;
  assign read_color_o = res_color_q;
  assign status_o     = res_status_q;

endmodule

// File: tb/sv/tb_argb32_framebuffer_fill_engine_core.sv
// Self-checking testbench for argb32_framebuffer_fill_engine_core: drives drawing
// commands and APB register writes, predicts every result from a private pixel store.
// Depends on fbf_pkg and the engine RTL.

module tb_argb32_framebuffer_fill_engine_core;
  timeunit 1ns;
  timeprecision 1ps;

  import fbf_pkg::*;

  localparam int QUIET_LIMIT = 50000;
  localparam logic [2:0] FN_UNDEF_FIRST = 3'd5;
  localparam logic [2:0] FN_UNDEF_LAST  = 3'd7;
  localparam int DEF_WIDTH  = 64;
  localparam int DEF_HEIGHT = 64;
  localparam int DEF_PITCH  = 64;
  localparam int DEF_BASE   = 0;

  typedef struct {
    logic [2:0]      func;
    logic [CW-1:0]   xa;
    logic [CW-1:0]   ya;
    logic [CW-1:0]   xb;
    logic [CW-1:0]   yb;
    logic [PIXW-1:0] color;
  } draw_cmd_t;

  typedef struct packed {
    logic [PIXW-1:0] read_color;
    logic            status;
  } answer_t;

  logic            clk_i;
  logic            rst_ni;
  logic            start_i;
  logic            busy_o;
  logic [2:0]      func_i;
  logic [CW-1:0]   x_a_i;
  logic [CW-1:0]   y_a_i;
  logic [CW-1:0]   x_b_i;
  logic [CW-1:0]   y_b_i;
  logic [PIXW-1:0] color_i;
  logic            done_o;
  logic [PIXW-1:0] read_color_o;
  logic            status_o;
  logic            psel;
  logic            penable;
  logic            pwrite;
  logic [PAW-1:0]  paddr;
  logic [31:0]     pwdata;
  logic [31:0]     prdata;
  logic            pready;

  // private copy of the engine state
  cfg_t            geom;
  logic [PIXW-1:0] pix_mem     [STORE_WORDS];
  bit              pix_written [STORE_WORDS];
  int              last_x;
  int              last_y;

  answer_t answer_q[$];
  int      err_cnt;
  int      cmds_sent;
  int      results_seen;
  int      geom_count;
  int      quiet_cycles;

  argb32_framebuffer_fill_engine_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .func_i       (func_i),
    .x_a_i        (x_a_i),
    .y_a_i        (y_a_i),
    .x_b_i        (x_b_i),
    .y_b_i        (y_b_i),
    .color_i      (color_i),
    .done_o       (done_o),
    .read_color_o (read_color_o),
    .status_o     (status_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  // ---------------------------------------------------------------- predictor
  function automatic bit on_x(int v);
    return v >= 0 && v < int'(geom.fb_width);
  endfunction

  function automatic bit on_y(int v);
    return v >= 0 && v < int'(geom.fb_height);
  endfunction

  function automatic logic [AW-1:0] pix_addr(int x, int y);
    int a;
    a = int'(geom.base_word) + y * int'(geom.row_pitch) + x;
    return AW'(a % STORE_WORDS);
  endfunction

  task automatic paint(input int x, input int y, input logic [PIXW-1:0] c);
    logic [AW-1:0] a;
    a = pix_addr(x, y);
    pix_mem[a]     = c;
    pix_written[a] = 1'b1;
    last_x = x;
    last_y = y;
  endtask

  task automatic paint_row(input int xa, input int xb, input int y,
                           input logic [PIXW-1:0] c);
    int lo;
    int hi;
    lo = (xa < xb) ? xa : xb;
    hi = (xa < xb) ? xb : xa;
    for (int x = lo; x <= hi; x++) paint(x, y, c);
  endtask

  task automatic execute_draw_cmd(input draw_cmd_t c);
    int xa;
    int ya;
    int xb;
    int yb;
    int lo;
    int hi;
    answer_t ans;
    xa = $signed(c.xa);
    ya = $signed(c.ya);
    xb = $signed(c.xb);
    yb = $signed(c.yb);
    ans = '0;
    case (c.func)
      FN_SET: begin
        if (on_x(xa) && on_y(ya)) paint(xa, ya, c.color);
        else ans.status = 1'b1;
      end
      FN_GET: begin
        if (on_x(xa) && on_y(ya)) ans.read_color = pix_mem[pix_addr(xa, ya)];
        else ans.status = 1'b1;
      end
      FN_HLINE: begin
        if (on_y(ya) && on_x(xa) && on_x(xb)) paint_row(xa, xb, ya, c.color);
        else ans.status = 1'b1;
      end
      FN_VLINE: begin
        if (on_x(xa) && on_y(ya) && on_y(yb)) begin
          lo = (ya < yb) ? ya : yb;
          hi = (ya < yb) ? yb : ya;
          for (int y = lo; y <= hi; y++) paint(xa, y, c.color);
        end else begin
          ans.status = 1'b1;
        end
      end
      FN_RECT: begin
        // x is put in order, but y1 > y2 simply draws no rows
        if (on_x(xa) && on_x(xb) && on_y(ya) && on_y(yb)) begin
          for (int y = ya; y <= yb; y++) paint_row(xa, xb, y, c.color);
        end else begin
          ans.status = 1'b1;
        end
      end
      default: ans.status = 1'b1;
    endcase
    answer_q.push_back(ans);
    cmds_sent++;
  endtask

  // ---------------------------------------------------------------- result check
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (answer_q.size() == 0) begin
        report_mismatch("result with nothing pending", read_color_o, '0);
      end else begin
        answer_t exp_ans;
        exp_ans = answer_q.pop_front();
        results_seen++;
        if (read_color_o !== exp_ans.read_color)
          report_mismatch("read_color", read_color_o, exp_ans.read_color);
        if (status_o !== exp_ans.status)
          report_mismatch("status", 32'(status_o), 32'(exp_ans.status));
      end
    end
  end

  // stall detector: nothing taken, nothing answered, no register access
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o || (psel && penable)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TIMEOUT after %0d quiet cycles, %0d results pending",
                 quiet_cycles, answer_q.size());
        $display("simulation failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- drivers
  task automatic send_cmd(input draw_cmd_t c, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    func_i  <= c.func;
    x_a_i   <= c.xa;
    y_a_i   <= c.ya;
    x_b_i   <= c.xb;
    y_b_i   <= c.yb;
    color_i <= c.color;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    execute_draw_cmd(c);
  endtask

  task automatic finish_commands();
    start_i <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk_i);
    // back end goes idle right after its last answer; small margin anyway
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_access(input reg_e r, input bit wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= PAW'({r, 2'b00});
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_reg(input reg_e r, input logic [31:0] want);
    logic [31:0] got;
    apb_access(r, 1'b0, '0, got);
    if (got !== want) report_mismatch({"register ", r.name()}, got, want);
  endtask

  task automatic put_reg(input reg_e r, input logic [31:0] v);
    logic [31:0] unused;
    apb_access(r, 1'b1, v, unused);
    check_reg(r, v);
  endtask

  // only call with the engine idle
  task automatic set_geometry(input int w, input int h, input int pitch, input int base);
    put_reg(REG_WIDTH, 32'(w));
    put_reg(REG_HEIGHT, 32'(h));
    put_reg(REG_PITCH, 32'(pitch));
    put_reg(REG_BASE, 32'(base));
    geom.fb_width  = UW'(w);
    geom.fb_height = UW'(h);
    geom.row_pitch = PITCHW'(pitch);
    geom.base_word = BASEW'(base);
    geom_count++;
  endtask

  // ---------------------------------------------------------------- generators
  function automatic draw_cmd_t mk_cmd(input logic [2:0] f, input int xa, input int ya,
                                       input int xb, input int yb,
                                       input logic [PIXW-1:0] c);
    draw_cmd_t cmd;
    cmd.func  = f;
    cmd.xa    = CW'(xa);
    cmd.ya    = CW'(ya);
    cmd.xb    = CW'(xb);
    cmd.yb    = CW'(yb);
    cmd.color = c;
    return cmd;
  endfunction

  // mostly inside [0, lim), sometimes negative or past the limit
  function automatic logic [CW-1:0] pick_coord(input int lim);
    int r;
    r = $urandom_range(99);
    if (r < 84 && lim > 0) return CW'($urandom_range(lim - 1, 0));
    if (r < 92) return CW'(12'h800 | CW'($urandom_range(2047, 0)));
    return CW'($urandom_range(2047, lim));
  endfunction

  function automatic logic [CW-1:0] pick_near(input logic [CW-1:0] a, input int lim,
                                              input int span);
    int av;
    int lo;
    int hi;
    av = $signed(a);
    if (av >= 0 && av < lim && $urandom_range(99) < 90) begin
      lo = (av - span < 0) ? 0 : av - span;
      hi = (av + span > lim - 1) ? lim - 1 : av + span;
      return CW'($urandom_range(hi, lo));
    end
    return pick_coord(lim);
  endfunction

  // short spans keep the run fast; a few reach across the whole frame
  function automatic int pick_span();
    int r;
    r = $urandom_range(99);
    if (r < 1) return 2047;
    if (r < 5) return 32;
    return 8;
  endfunction

  function automatic draw_cmd_t pick_cmd();
    draw_cmd_t c;
    int w;
    int h;
    int r;
    int span;
    int gx;
    int gy;
    bit found;
    logic [CW-1:0] t;
    w = geom.fb_width;
    h = geom.fb_height;
    // unused operands carry noise
    c.xa    = CW'($urandom);
    c.ya    = CW'($urandom);
    c.xb    = CW'($urandom);
    c.yb    = CW'($urandom);
    c.color = $urandom;
    span    = pick_span();
    r       = $urandom_range(99);
    if (r < 25) begin
      c.func = FN_SET;
      c.xa   = pick_coord(w);
      c.ya   = pick_coord(h);
    end else if (r < 50) begin
      // only ever read words that have been painted
      c.func = FN_GET;
      found  = 1'b0;
      for (int i = 0; i < 8 && !found; i++) begin
        if ($urandom_range(1)) begin
          gx = last_x;
          gy = last_y;
        end else begin
          gx = (w > 0) ? $urandom_range(w - 1, 0) : 0;
          gy = (h > 0) ? $urandom_range(h - 1, 0) : 0;
        end
        if (on_x(gx) && on_y(gy) && pix_written[pix_addr(gx, gy)]) found = 1'b1;
      end
      if (found) begin
        c.xa = CW'(gx);
        c.ya = CW'(gy);
      end else begin
        c.xa = CW'(12'h800 | CW'($urandom_range(2047, 0)));
      end
    end else if (r < 65) begin
      c.func = FN_HLINE;
      c.xa   = pick_coord(w);
      c.xb   = pick_near(c.xa, w, span);
      c.ya   = pick_coord(h);
    end else if (r < 80) begin
      c.func = FN_VLINE;
      c.xa   = pick_coord(w);
      c.ya   = pick_coord(h);
      c.yb   = pick_near(c.ya, h, span);
    end else if (r < 95) begin
      if (span > 32) span = 32;
      c.func = FN_RECT;
      c.xa   = pick_coord(w);
      c.xb   = pick_near(c.xa, w, span);
      c.ya   = pick_coord(h);
      c.yb   = pick_near(c.ya, h, span);
      if ($signed(c.yb) < $signed(c.ya) && $urandom_range(99) < 60) begin
        t    = c.ya;
        c.ya = c.yb;
        c.yb = t;
      end
    end else begin
      c.func = 3'($urandom_range(FN_UNDEF_LAST, FN_UNDEF_FIRST));
    end
    return c;
  endfunction

  task automatic run_random(input int n, input int idle_pct);
    for (int i = 0; i < n; i++) send_cmd(pick_cmd(), idle_pct);
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_register_defaults();
    check_reg(REG_WIDTH, DEF_WIDTH);
    check_reg(REG_HEIGHT, DEF_HEIGHT);
    check_reg(REG_PITCH, DEF_PITCH);
    check_reg(REG_BASE, DEF_BASE);
  endtask

  task automatic test_directed_commands();
    logic [2:0] f;
    // unused operands at their extremes must not matter
    send_cmd(mk_cmd(FN_SET, 0, 0, -2048, 2047, 32'hFFFF_FFFF), 0);
    send_cmd(mk_cmd(FN_SET, 63, 63, 2047, -2048, 32'h0000_0000), 0);
    send_cmd(mk_cmd(FN_GET, 0, 0, 0, 0, 32'h1234_5678), 0);
    send_cmd(mk_cmd(FN_GET, 63, 63, 0, 0, '0), 0);
    send_cmd(mk_cmd(FN_GET, 64, 0, 0, 0, '0), 0);
    send_cmd(mk_cmd(FN_GET, 0, -2048, 0, 0, '0), 0);
    send_cmd(mk_cmd(FN_SET, 2047, 5, 0, 0, 32'hDEAD_BEEF), 0);
    send_cmd(mk_cmd(FN_SET, -1, 0, 0, 0, 32'hDEAD_BEEF), 0);
    // reversed ends
    send_cmd(mk_cmd(FN_HLINE, 10, 2, 3, 0, 32'hA5A5_0001), 0);
    send_cmd(mk_cmd(FN_GET, 3, 2, 0, 0, '0), 0);
    send_cmd(mk_cmd(FN_GET, 10, 2, 0, 0, '0), 0);
    send_cmd(mk_cmd(FN_VLINE, 5, 20, 0, 12, 32'h5A5A_0002), 0);
    send_cmd(mk_cmd(FN_GET, 5, 12, 0, 0, '0), 0);
    send_cmd(mk_cmd(FN_RECT, 30, 40, 25, 42, 32'h00FF_00FF), 0);
    send_cmd(mk_cmd(FN_GET, 25, 42, 0, 0, '0), 0);
    // y1 > y2: done, nothing drawn
    send_cmd(mk_cmd(FN_RECT, 25, 42, 30, 40, 32'hFF00_FF00), 0);
    send_cmd(mk_cmd(FN_GET, 25, 42, 0, 0, '0), 0);
    send_cmd(mk_cmd(FN_HLINE, 0, 3, 64, 0, 32'h1111_1111), 0);
    send_cmd(mk_cmd(FN_VLINE, 7, 3, 0, -5, 32'h2222_2222), 0);
    send_cmd(mk_cmd(FN_RECT, 0, 0, 64, 10, 32'h3333_3333), 0);
    for (f = FN_UNDEF_FIRST; f <= FN_UNDEF_LAST && f >= FN_UNDEF_FIRST; f++)
      send_cmd(mk_cmd(f, 1, 1, 1, 1, 32'h4444_4444), 0);
    send_cmd(mk_cmd(FN_RECT, 63, 0, 63, 0, 32'h8000_0001), 0);
    send_cmd(mk_cmd(FN_GET, 63, 0, 0, 0, '0), 0);
    send_cmd(mk_cmd(FN_HLINE, 63, 63, 0, 0, 32'h7FFF_FFFE), 0);
    send_cmd(mk_cmd(FN_GET, 63, 63, 0, 0, '0), 0);
  endtask

  task automatic test_geometry_corners();
    finish_commands();
    set_geometry(0, 0, 0, 0);          // everything rejected
    run_random(30, 34);

    finish_commands();
    set_geometry(2047, 2047, 4095, 4095);   // addresses wrap around the store
    send_cmd(mk_cmd(FN_SET, 2046, 2046, 0, 0, 32'hC0FF_EE00), 75);
    send_cmd(mk_cmd(FN_GET, 2046, 2046, 0, 0, '0), 75);
    run_random(30, 75);

    finish_commands();
    set_geometry(2047, 1, 0, 123);
    send_cmd(mk_cmd(FN_HLINE, 2046, 0, 0, 0, 32'h0F0F_0F0F), 0);
    send_cmd(mk_cmd(FN_GET, 1000, 0, 0, 0, '0), 0);
    run_random(30, 0);

    finish_commands();
    set_geometry(1, 2047, 4095, 0);
    send_cmd(mk_cmd(FN_VLINE, 0, 2046, 0, 0, 32'hF0F0_F0F0), 34);
    send_cmd(mk_cmd(FN_GET, 0, 2046, 0, 0, '0), 34);
    run_random(30, 34);

    finish_commands();
    set_geometry(13, 9, 7, 4090);
    send_cmd(mk_cmd(FN_RECT, 12, 0, 0, 8, 32'h0BAD_F00D), 0);
    send_cmd(mk_cmd(FN_GET, 12, 8, 0, 0, '0), 0);
    run_random(30, 0);
  endtask

  task automatic test_random_traffic();
    int idle_list [3] = '{0, 75, 34};
    int w;
    foreach (idle_list[p]) begin
      finish_commands();
      w = $urandom_range(160, 1);
      set_geometry(w, $urandom_range(160, 1),
                   (p == 0) ? w : $urandom_range(4095, 0), $urandom_range(4095, 0));
      run_random(210, idle_list[p]);
      finish_commands();          // hold off until every answer is back
      run_random(210, idle_list[p]);
    end
  endtask

  initial begin
    rst_ni  = 1'b0;
    start_i = 1'b0;
    func_i  = '0;
    x_a_i   = '0;
    y_a_i   = '0;
    x_b_i   = '0;
    y_b_i   = '0;
    color_i = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    err_cnt      = 0;
    cmds_sent    = 0;
    results_seen = 0;
    geom_count   = 0;
    quiet_cycles = 0;
    last_x       = 0;
    last_y       = 0;
    geom.fb_width  = UW'(DEF_WIDTH);
    geom.fb_height = UW'(DEF_HEIGHT);
    geom.row_pitch = PITCHW'(DEF_PITCH);
    geom.base_word = BASEW'(DEF_BASE);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_defaults();
    test_directed_commands();
    test_geometry_corners();
    test_random_traffic();

    finish_commands();
    repeat (10) @(posedge clk_i);
    $display("Covered %0d commands (all five ops, bad codes, rejects, wraps) under %0d",
             cmds_sent, geom_count + 1);
    $display("register settings; %0d answers compared, %0d mismatches",
             results_seen, err_cnt);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
